// ===== hdl/sgr_pkg.sv =====
package sgr_pkg;

    localparam int CELL_WIDTH_DEF  = 8;
    localparam int CELL_HEIGHT_DEF = 8;
    localparam int GLYPH_COUNT     = 129;
    localparam int GLYPH_ROWS      = 8;
    localparam int WIDE_GLYPH      = 128;
    localparam int LANES           = 32;
    localparam int THR_N           = 7;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [5:0] SCALE_MIN   = 6'd2;
    localparam logic [5:0] SCALE_MAX   = 6'd40;
    localparam logic [5:0] SCALE_RESET = 6'd10;

    localparam logic [13:0] SCREEN_W_RESET = 14'd640;
    localparam logic [13:0] SCREEN_H_RESET = 14'd480;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 144;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_FONT_SCALE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 2'd3;

    localparam logic [1:0] PIX_555   = 2'd0;
    localparam logic [1:0] PIX_565   = 2'd1;
    localparam logic [1:0] PIX_24    = 2'd2;
    localparam logic [1:0] PIX_32    = 2'd3;
    localparam logic [1:0] PIX_RESET = PIX_32;

    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

    typedef struct packed {
        logic [5:0]                  w;
        logic [6:0]                  h;
        logic [5:0]                  rows;
        logic [LANES-1:0]            wmask;
        logic [LANES-1:0][2:0]       col_map;
        logic [THR_N-1:0][8:0]       thr;
    } geom_t;

    typedef struct packed {
        logic [13:0] bx;
        logic [14:0] ybase;
        logic [23:0] fg;
        logic [23:0] bg;
        logic [63:0] glyph;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic       busy;
        logic [4:0] cy;
    } bk_status_t;

    // x/10 for x < 1024
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:11];
    endfunction

    function automatic logic [23:0] pack_colour(input logic [23:0] c, input logic [1:0] fmt);
        logic [23:0] r;
        unique case (fmt)
            PIX_555: r = ((c >> 9) & 24'h7c00) | ((c >> 6) & 24'h3e0) | ((c >> 3) & 24'h1f);
            PIX_565: r = ((c >> 8) & 24'hf800) | ((c >> 5) & 24'h7e0) | ((c >> 3) & 24'h1f);
            PIX_24:  r = c;
            PIX_32:  r = c;
        endcase
        return r;
    endfunction

    function automatic geom_t calc_geom(input logic [5:0] scale, input logic [3:0] cell_w,
                                        input logic [4:0] cell_h);
        logic [5:0] sc;
        logic [9:0] pw;
        logic [9:0] ph;
        logic [9:0] pr;
        logic [6:0] wq;
        logic [6:0] rq;
        logic [8:0] ten_k;
        logic [2:0] cnt;
        geom_t      g;
        if (scale < SCALE_MIN)
            sc = SCALE_MIN;
        else if (scale > SCALE_MAX)
            sc = SCALE_MAX;
        else
            sc = scale;
        pw = 10'(cell_w) * 10'(sc);
        ph = 10'(cell_h) * 10'(sc);
        pr = 10'(GLYPH_ROWS) * 10'(sc);
        wq = div10(pw);
        rq = div10(pr);
        g.w    = (wq > 7'(LANES)) ? 6'(LANES) : wq[5:0];
        g.h    = div10(ph);
        g.rows = (rq > 7'(LANES)) ? 6'(LANES) : rq[5:0];
        for (int j = 0; j < THR_N; j++)
            g.thr[j] = 9'(j + 1) * 9'(sc);
        for (int k = 0; k < LANES; k++)
        begin
            ten_k = 9'(k * 10);
            cnt = 3'd0;
            for (int j = 0; j < THR_N; j++)
            begin
                if (g.thr[j] <= ten_k)
                    cnt = cnt + 3'd1;
            end
            g.col_map[k] = cnt;
            g.wmask[k]   = 6'(k) < g.w;
        end
        return g;
    endfunction

endpackage

// ===== hdl/scaled_glyph_rasterizer_core.sv =====
// A draw item's first row reaches m_tvalid via intake register, queue, row sequencer
// and output register. Throughput: one row per cycle unless m_tready stalls;
// draws give floor(8*s/10) rows, s = font_scale clamped to 2..40 (8 at native size).
// A 4-entry queue decouples item intake from row output.
// Reset (rst_n low, async) clears control state and loads register defaults;
// the glyph store is not cleared and must be loaded before use.
module scaled_glyph_rasterizer_core #(
    parameter int CELL_WIDTH  = sgr_pkg::CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = sgr_pkg::CELL_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // char_code, attribute, cell_x, cell_y, glyph_index, glyph_bits, zero pad
    input  logic [sgr_pkg::IN_TDATA_W-1:0]    s_tdata,
    // action
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // row_x, row_y, set_mask, draw_mask, fg_pixel, bg_pixel, zero pad
    output logic [sgr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [sgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sgr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sgr_pkg::*;

    geom_t       geom;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [1:0]  pixel_format;
    q_status_t   q_status;
    bk_status_t  bk_status;
    logic        push;
    logic        pop;
    entry_t      push_entry;
    entry_t      head;

    sgr_cfg #(
        .CELL_WIDTH  (CELL_WIDTH),
        .CELL_HEIGHT (CELL_HEIGHT)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .geom          (geom),
        .screen_width  (screen_width),
        .screen_height (screen_height),
        .pixel_format  (pixel_format)
    );

    sgr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .geom         (geom),
        .pixel_format (pixel_format),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    sgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    sgr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .geom          (geom),
        .screen_width  (screen_width),
        .screen_height (screen_height),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .status        (bk_status)
    );

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.busy |-> (6'(bk_status.cy) < geom.rows))
        else $error("row counter beyond glyph rows");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_status.full)
        else $error("intake stalled with queue space free");

    a_idle_back_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (!bk_status.busy && !q_status.empty) |=> bk_status.busy)
        else $error("row sequencer idle while queue holds an item");

endmodule

// ===== hdl/sgr_cfg.sv =====
module sgr_cfg #(
    parameter int CELL_WIDTH  = sgr_pkg::CELL_WIDTH_DEF,
    parameter int CELL_HEIGHT = sgr_pkg::CELL_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sgr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output sgr_pkg::geom_t                   geom,
    output logic [13:0]                      screen_width,
    output logic [13:0]                      screen_height,
    output logic [1:0]                       pixel_format
);
    import sgr_pkg::*;

    logic [13:0] sw_reg;
    logic [13:0] sh_reg;
    logic [1:0]  fmt_reg;
    geom_t       geom_reg;

    // geometry is recomputed when the scale is written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg <= calc_geom(SCALE_RESET, 4'(CELL_WIDTH), 5'(CELL_HEIGHT));
            sw_reg   <= SCREEN_W_RESET;
            sh_reg   <= SCREEN_H_RESET;
            fmt_reg  <= PIX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FONT_SCALE:    geom_reg <= calc_geom(cfg_wdata[5:0], 4'(CELL_WIDTH),
                                                         5'(CELL_HEIGHT));
                REG_SCREEN_WIDTH:  sw_reg   <= cfg_wdata[13:0];
                REG_SCREEN_HEIGHT: sh_reg   <= cfg_wdata[13:0];
                REG_PIXEL_FORMAT:  fmt_reg  <= cfg_wdata[1:0];
            endcase
        end
    end

    assign geom          = geom_reg;
    assign screen_width  = sw_reg;
    assign screen_height = sh_reg;
    assign pixel_format  = fmt_reg;

endmodule

// ===== hdl/sgr_front.sv =====
module sgr_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sgr_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                       s_tuser,
    input  sgr_pkg::geom_t                   geom,
    input  logic [1:0]                       pixel_format,
    input  sgr_pkg::q_status_t               q_status,
    output logic                             push,
    output sgr_pkg::entry_t                  push_entry
);
    import sgr_pkg::*;

    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [8:0]  cell_x;
    logic [7:0]  cell_y;
    logic [7:0]  glyph_index;
    logic [63:0] glyph_bits;
    logic        accept;
    logic        is_load;
    logic [7:0]  rd_addr;

    logic [63:0] glyph_mem [GLYPH_COUNT];
    logic        s1_valid_reg;
    entry_t      s1_reg;

    assign char_code   = s_tdata[7:0];
    assign attribute   = s_tdata[15:8];
    assign cell_x      = s_tdata[24:16];
    assign cell_y      = s_tdata[32:25];
    assign glyph_index = s_tdata[40:33];
    assign glyph_bits  = s_tdata[104:41];

    assign is_load  = s_tuser[0] == ACT_LOAD;
    assign s_tready = !s1_valid_reg || !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = s1_valid_reg && !q_status.full;
    assign rd_addr  = char_code[7] ? 8'(WIDE_GLYPH) : char_code;

    always_ff @(posedge clk)
    begin
        if (accept && is_load && (9'(glyph_index) < 9'(GLYPH_COUNT)))
            glyph_mem[glyph_index] <= glyph_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept && !is_load)
            s1_valid_reg <= 1'b1;
        else if (push)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_load)
        begin
            s1_reg.bx    <= 14'(cell_x * geom.w);
            s1_reg.ybase <= 15'(cell_y * geom.h);
            s1_reg.fg    <= pack_colour(PALETTE[attribute[3:0]], pixel_format);
            s1_reg.bg    <= pack_colour(PALETTE[attribute[7:4]], pixel_format);
            s1_reg.glyph <= glyph_mem[rd_addr];
        end
    end

    assign push_entry = s1_reg;

endmodule

// ===== hdl/sgr_queue.sv =====
module sgr_queue #(
    parameter int DEPTH = sgr_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sgr_pkg::entry_t     push_entry,
    input  logic                pop,
    output sgr_pkg::entry_t     head,
    output sgr_pkg::q_status_t  status
);
    import sgr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             q_mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign head         = q_mem[rd_ptr_reg];
    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;

endmodule

// ===== hdl/sgr_back.sv =====
module sgr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sgr_pkg::entry_t                   head,
    input  sgr_pkg::q_status_t                q_status,
    output logic                              pop,
    input  sgr_pkg::geom_t                    geom,
    input  logic [13:0]                       screen_width,
    input  logic [13:0]                       screen_height,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sgr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output sgr_pkg::bk_status_t               status
);
    import sgr_pkg::*;

    logic                 cur_valid_reg;
    entry_t               cur_reg;
    logic [LANES-1:0]     colmask_reg;
    logic [4:0]           cy_reg;

    logic                 m_valid_reg;
    logic [13:0]          row_x_reg;
    logic [13:0]          row_y_reg;
    logic [LANES-1:0]     set_reg;
    logic [LANES-1:0]     draw_reg;
    logic [23:0]          fg_reg;
    logic [23:0]          bg_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 adv;
    logic                 last;
    logic [14:0]          y;
    logic [8:0]           ten_cy;
    logic [2:0]           ry;
    logic [7:0]           rowbits;
    logic [LANES-1:0]     set_next;
    logic [LANES-1:0]     draw_next;
    logic [14:0]          avail;
    logic [LANES-1:0]     colmask_next;

    assign out_free = !m_valid_reg || m_tready;
    assign adv      = cur_valid_reg && out_free;
    assign last     = (6'(cy_reg) + 6'd1) == geom.rows;
    assign pop      = !q_status.empty && (!cur_valid_reg || (adv && last));

    // columns of the new cell that fall left of the screen edge
    assign avail = {1'b0, screen_width} - {1'b0, head.bx};
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
            colmask_next[k] = geom.wmask[k] && !avail[14] && (15'(k) < avail);
    end

    assign y      = cur_reg.ybase + 15'(cy_reg);
    assign ten_cy = 9'(cy_reg) * 9'd10;

    always_comb
    begin
        ry = 3'd0;
        for (int j = 0; j < THR_N; j++)
        begin
            if (geom.thr[j] <= ten_cy)
                ry = ry + 3'd1;
        end
        for (int c = 0; c < 8; c++)
            rowbits[c] = cur_reg.glyph[{3'(c), ry}];
        for (int k = 0; k < LANES; k++)
            set_next[k] = geom.wmask[k] && rowbits[geom.col_map[k]];
        draw_next = (y < {1'b0, screen_height}) ? colmask_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cy_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                cy_reg        <= '0;
            end
            else if (adv && last)
                cur_valid_reg <= 1'b0;
            else if (adv)
                cy_reg <= cy_reg + 5'd1;

            if (adv)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg     <= head;
            colmask_reg <= colmask_next;
        end
        if (adv)
        begin
            row_x_reg <= cur_reg.bx;
            row_y_reg <= y[13:0];
            set_reg   <= set_next;
            draw_reg  <= draw_next;
            fg_reg    <= cur_reg.fg;
            bg_reg    <= cur_reg.bg;
            last_reg  <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0, bg_reg, fg_reg, draw_reg, set_reg, row_y_reg, row_x_reg};

    assign status.busy = cur_valid_reg;
    assign status.cy   = cy_reg;

endmodule
